FILE: sv/rbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramped burst generator package
// Shared widths, register indexes and the divider status type.
// ----------------------------------------------------------------------------
package rbg_pkg;

  // Width of a sample and of an envelope-scaled quotient.
  localparam int SAMPLE_W = 16;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TIME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_TIME   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TIME  = 3'd6;

  // Sample source codes.
  localparam logic MODE_HARMONIC = 1'b0;
  localparam logic MODE_NOISE    = 1'b1;

  // Status of the iterative divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: sv/ramped_burst_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramped burst generator
// One sample per input transaction of a repeating burst with a linear rise
// and fall envelope; sine or noise source.
//
//   Channel  Signals                              Direction  Moves
//   in       in_valid_i / in_stall_o              sink       random_word_i
//   out      out_valid_o / out_stall_i            source     amplitude_o, active_o
//   cfg      cfg_valid_i / cfg_ready_o            sink       cfg_index_i, cfg_data_i
//
// A silent sample goes from acceptance through the result register to the
// output register, a full-scale sample also through envelope setup. A ramped
// sample passes envelope setup, one multiply, the restoring divider, hand-over.
// One sample is in work at a time; in_stall_o is high until it is stored.
// The output register holds one result, so a stalled output delays only
// the hand-over of the next result. Reset loads the register defaults.
// ----------------------------------------------------------------------------
module ramped_burst_generator #(
  parameter int COUNT_BITS      = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [15:0]                       random_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [15:0]                amplitude_o,
  output logic                              active_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rbg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rbg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rbg_pkg::*;

  // Counter registers keep at most 16 bits.
  localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ENV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic          mode_q, mode_d;
  logic [15:0]   step_q, step_d;
  logic [CW-1:0] delay_q, delay_d;
  logic [CW-1:0] dur_q, dur_d;
  logic [CW-1:0] rise_q, rise_d;
  logic [CW-1:0] fall_q, fall_d;
  logic [CW-1:0] sleep_q, sleep_d;

  // Burst state.
  logic [CW-1:0]      wait_q, wait_d;
  logic signed [CW:0] env_q, env_d;
  logic [15:0]        phase_q, phase_d;

  // Per-sample work registers.
  logic [CW-1:0]       e_q, e_d;
  logic                harm_q, harm_d;
  logic [15:0]         word_q, word_d;
  logic [SAMPLE_W-1:0] mag_q, mag_d;
  logic [CW-1:0]       num_q, num_d;
  logic [CW-1:0]       den_q, den_d;
  logic                neg_q, neg_d;
  logic [15:0]         res_amp_q, res_amp_d;
  logic                res_act_q, res_act_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_amp_q, out_amp_d;
  logic        out_act_q, out_act_d;

  logic in_fire;
  logic cfg_fire;
  logic out_load;

  logic signed [CW:0]  env_dec;
  logic [15:0]         sample;
  logic                s_neg;
  logic [SAMPLE_W-1:0] s_mag;
  logic [CW:0]         ramp_sum;
  logic [CW-1:0]       rise_num;
  logic                in_fall;
  logic                in_rise;
  logic [CW-1:0]       sel_num;
  logic [CW-1:0]       sel_den;

  logic signed [SAMPLE_W-1:0] sine;
  logic                       div_start;
  div_stat_t                  div_stat;
  logic [SAMPLE_W-1:0]        quotient;
  logic [SAMPLE_W+CW-1:0]     product;

  assign in_stall_o  = state_q != ST_IDLE;
  assign cfg_ready_o = state_q == ST_IDLE;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_load    = (state_q == ST_PUSH) && (!out_valid_q || !out_stall_i);
  assign div_start   = (state_q == ST_MUL) && !div_stat.busy;

  // Sine of the phase before this tick's advance, read at acceptance.
  rbg_sine #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine (
    .clk_i  (clk_i),
    .en_i   (in_fire),
    .phase_i(phase_q),
    .sine_o (sine)
  );

  // Magnitude times ramp numerator, full width.
  assign product = (SAMPLE_W+CW)'(mag_q) * (SAMPLE_W+CW)'(num_q);

  // Divider for the envelope ratio.
  rbg_div #(
    .DEN_W(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(product),
    .divisor_i (den_q),
    .stat_o    (div_stat),
    .quotient_o(quotient)
  );

  // Sample source, its sign and magnitude.
  assign env_dec = env_q - (CW+1)'(1);
  assign sample  = harm_q ? sine : {~word_q[15], word_q[14:0]};
  assign s_neg   = sample[15];
  assign s_mag   = s_neg ? (~sample + 16'd1) : sample;

  // Envelope segment selection.
  assign ramp_sum = {1'b0, e_q} + {1'b0, rise_q};
  assign rise_num = (e_q >= dur_q) ? '0 : (dur_q - e_q);
  assign in_fall  = e_q < fall_q;
  assign in_rise  = ramp_sum > {1'b0, dur_q};
  assign sel_num  = in_fall ? e_q : rise_num;
  assign sel_den  = in_fall ? fall_q : rise_q;

  // Sequencer, counters and configuration writes.
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    step_d    = step_q;
    delay_d   = delay_q;
    dur_d     = dur_q;
    rise_d    = rise_q;
    fall_d    = fall_q;
    sleep_d   = sleep_q;
    wait_d    = wait_q;
    env_d     = env_q;
    phase_d   = phase_q;
    e_d       = e_q;
    harm_d    = harm_q;
    word_d    = word_q;
    mag_d     = mag_q;
    num_d     = num_q;
    den_d     = den_q;
    neg_d     = neg_q;
    res_amp_d = res_amp_q;
    res_act_d = res_act_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          word_d    = random_word_i;
          harm_d    = mode_q == MODE_HARMONIC;
          res_amp_d = '0;
          res_act_d = 1'b0;
          state_d   = ST_PUSH;
          if (wait_q != '0) begin
            wait_d = wait_q - CW'(1);
          end else if (mode_q == MODE_HARMONIC) begin
            if (env_dec[CW]) begin
              // End of burst: restart phase from the random word.
              phase_d = random_word_i;
              wait_d  = (sleep_q == '0) ? '0 : (sleep_q - CW'(1));
              env_d   = $signed({1'b0, dur_q});
            end else begin
              env_d     = env_dec;
              e_d       = env_dec[CW-1:0];
              phase_d   = phase_q + step_q;
              res_act_d = 1'b1;
              state_d   = ST_ENV;
            end
          end else begin
            if (env_q[CW]) begin
              wait_d = sleep_q;
              env_d  = $signed({1'b0, dur_q});
            end else begin
              env_d     = env_dec;
              e_d       = env_q[CW-1:0];
              res_act_d = 1'b1;
              state_d   = ST_ENV;
            end
          end
        end
      end
      ST_ENV: begin
        mag_d = s_mag;
        neg_d = s_neg;
        num_d = sel_num;
        den_d = sel_den;
        if (!in_fall && !in_rise) begin
          res_amp_d = sample;
          state_d   = ST_PUSH;
        end else if (sel_num == '0 || sel_den == '0) begin
          res_amp_d = '0;
          state_d   = ST_PUSH;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_amp_d = neg_q ? (~quotient + 16'd1) : quotient;
          state_d   = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Register writes; start delay and duration also load their counters.
    if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_MODE:        mode_d  = cfg_data_i[0];
        REG_PHASE_STEP:  step_d  = cfg_data_i;
        REG_START_DELAY: begin
          delay_d = cfg_data_i[CW-1:0];
          wait_d  = cfg_data_i[CW-1:0];
        end
        REG_DURATION: begin
          dur_d = cfg_data_i[CW-1:0];
          env_d = $signed({1'b0, cfg_data_i[CW-1:0]});
        end
        REG_RISE_TIME:   rise_d  = cfg_data_i[CW-1:0];
        REG_FALL_TIME:   fall_d  = cfg_data_i[CW-1:0];
        REG_SLEEP_TIME:  sleep_d = cfg_data_i[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Output register with its valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    out_amp_d   = out_amp_q;
    out_act_d   = out_act_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_amp_d   = res_amp_q;
      out_act_d   = res_act_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and configuration state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_HARMONIC;
      step_q      <= 16'd3277;
      delay_q     <= '0;
      dur_q       <= CW'(50);
      rise_q      <= CW'(10);
      fall_q      <= CW'(10);
      sleep_q     <= CW'(200);
      wait_q      <= '0;
      env_q       <= (CW+1)'(50);
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      step_q      <= step_d;
      delay_q     <= delay_d;
      dur_q       <= dur_d;
      rise_q      <= rise_d;
      fall_q      <= fall_d;
      sleep_q     <= sleep_d;
      wait_q      <= wait_d;
      env_q       <= env_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    e_q       <= e_d;
    harm_q    <= harm_d;
    word_q    <= word_d;
    mag_q     <= mag_d;
    num_q     <= num_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
    res_amp_q <= res_amp_d;
    res_act_q <= res_act_d;
    out_amp_q <= out_amp_d;
    out_act_q <= out_act_d;
  end

  assign out_valid_o = out_valid_q;
  assign amplitude_o = $signed(out_amp_q);
  assign active_o    = out_act_q;

endmodule

FILE: sv/rbg_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine lookup
// Quarter-wave table with quadrant folding and a registered Q1.15 output.
// ----------------------------------------------------------------------------
module rbg_sine #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [15:0]                       phase_i,
  output logic signed [rbg_pkg::SAMPLE_W-1:0] sine_o
);
  import rbg_pkg::*;

  localparam int QB    = SINE_TABLE_BITS - 2;
  localparam int QSIZE = 1 << QB;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned Q30One    = 64'd1 << 30;

  // Quarter-wave magnitude: Taylor series in unsigned Q30, rounded to Q1.15.
  function automatic logic [14:0] sine_mag(input int unsigned q, input int unsigned qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    longint unsigned m;
    x  = (longint'(q) * HalfPiQ30) >> qbits;
    x2 = (x * x) >> 30;
    t  = Q30One - x2 / 72;
    t  = Q30One - ((x2 * t) >> 30) / 42;
    t  = Q30One - ((x2 * t) >> 30) / 20;
    t  = Q30One - ((x2 * t) >> 30) / 6;
    y  = (x * t) >> 30;
    m  = (y * 32767 + (64'd1 << 29)) >> 30;
    if (m > 32767) begin
      m = 32767;
    end
    return m[14:0];
  endfunction

  logic [14:0]     lut [QSIZE+1];
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]      quad;
  logic [QB-1:0]   q_lo;
  logic [QB:0]     addr;
  logic [14:0]     mag;

  // Constant quarter-wave table.
  for (genvar g = 0; g <= QSIZE; g++) begin : g_lut
    assign lut[g] = sine_mag(g, QB);
  end

  // Fold the phase into the first quadrant.
  assign idx  = phase_i[15 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign q_lo = idx[QB-1:0];
  assign addr = quad[0] ? ((QB+1)'(QSIZE) - {1'b0, q_lo}) : {1'b0, q_lo};
  assign mag  = lut[addr];

  // Registered read with sign for the lower half cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_o <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

FILE: sv/rbg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider, one quotient bit per cycle, for a quotient that fits
// in one sample width.
// ----------------------------------------------------------------------------
module rbg_div #(
  parameter int DEN_W = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rbg_pkg::SAMPLE_W+DEN_W-1:0]  dividend_i,
  input  logic [DEN_W-1:0]                    divisor_i,
  output rbg_pkg::div_stat_t                  stat_o,
  output logic [rbg_pkg::SAMPLE_W-1:0]        quotient_o
);
  import rbg_pkg::*;

  localparam int StepW = $clog2(SAMPLE_W + 1);

  logic             busy_q, busy_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [SAMPLE_W-1:0] lo_q, lo_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic             last;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, lo_q[SAMPLE_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};
  assign last  = cnt_q == StepW'(SAMPLE_W);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    if (start_i) begin
      // The upper part is below the divisor since the quotient fits.
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i[SAMPLE_W+DEN_W-1:SAMPLE_W];
      lo_d   = dividend_i[SAMPLE_W-1:0];
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + StepW'(1);
        rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo_d  = {lo_q[SAMPLE_W-2:0], ge};
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    lo_q  <= lo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && last;
  assign quotient_o  = lo_q;

endmodule

FILE: sv/rbg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramped burst generator checker
// Port-level properties of the generator, bound to the top level.
// ----------------------------------------------------------------------------
module rbg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [15:0]                    random_word_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [15:0]             amplitude_o,
  input logic                           active_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [rbg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [rbg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(amplitude_o) && $stable(active_o))
    else $error("result payload changed while stalled");

  // A sample outside a burst is silent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_o |-> amplitude_o == 16'sd0)
    else $error("nonzero sample outside a burst");

  // The block is busy in the cycle after it takes a sample transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the sample finished");

  // Register writes are taken only while no sample is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> !in_stall_o)
    else $error("register write taken while busy");

endmodule

bind ramped_burst_generator rbg_checker u_rbg_checker (.*);
